[rtl/core/fba_pkg.sv]
// Package for the block allocator: table sizes, entry codes and types.
// Used by fba_ram users and the top level fat_block_allocator; no dependencies.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int TABLE_SIZE = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int ENTRY_W    = 10;
  localparam int BLOCK_W    = 9;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [IDX_W-1:0]   idx_t;

  localparam entry_t ENTRY_FREE = entry_t'(10'h3FE);
  localparam entry_t ENTRY_END  = entry_t'(10'h3FF);
  localparam entry_t TBL_LIM    = entry_t'(TABLE_SIZE);
  localparam idx_t   IDX_LAST   = idx_t'(TABLE_SIZE - 1);

  localparam logic [BLOCK_W-1:0] BLOCK_NONE = 9'h1FF;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [1:0] MODE_LINK  = 2'd3;

endpackage

[rtl/core/fba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/fat_block_allocator.sv]
// Top level of the block allocator: table control, scan and chain walk.
// Depends on fba_pkg and fba_ram.
`timescale 1ns / 1ps

// The allocation table lives in one RAM with a registered read; a valid bit per
// entry makes every entry read as free after reset, so the block takes words
// right out of reset. One word is handled at a time, and the next one is taken
// as soon as its predecessor's result sits in the output register. Allocate
// scans from index 0 up to the lowest free entry; find-last reads the entries
// along the chain. The table is read once per cycle, and in a chain walk each
// read address comes from the previous read.
module fat_block_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic signed [fba_pkg::BLOCK_W-1:0] in_block,
  input  logic [7:0]                        in_next_block,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fba_pkg::BLOCK_W-1:0] out_result_block,
  output logic                              out_chain_error
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  fba_pkg::idx_t                cur_r, cur_nxt;
  fba_pkg::idx_t                steps_r, steps_nxt;
  logic [fba_pkg::BLOCK_W-1:0]  res_r, res_nxt;
  logic                         err_r, err_nxt;
  logic [fba_pkg::TABLE_SIZE-1:0] valid_r;
  logic                         vld_q_r;
  logic                         out_valid_r;
  logic [fba_pkg::BLOCK_W-1:0]  out_res_r;
  logic                         out_err_r;

  logic                         in_acc;
  logic                         slot_free;
  logic                         blk_ok;
  logic                         nxt_ok;
  fba_pkg::idx_t                blk_idx;
  fba_pkg::idx_t                rd_addr;
  fba_pkg::entry_t              rd_data;
  logic                         wr_en;
  fba_pkg::idx_t                wr_addr;
  fba_pkg::entry_t              wr_data;
  logic                         set_vld;
  logic                         clr_vld;
  logic                         ent_free;
  logic                         ent_link;
  logic [fba_pkg::BLOCK_W-1:0]  cur_blk;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign blk_ok  = !in_block[fba_pkg::BLOCK_W-1] &&
                   (fba_pkg::entry_t'(in_block[7:0]) < fba_pkg::TBL_LIM);
  assign nxt_ok  = fba_pkg::entry_t'(in_next_block) < fba_pkg::TBL_LIM;
  assign blk_idx = in_block[fba_pkg::IDX_W-1:0];

  assign ent_free = !vld_q_r || (rd_data == fba_pkg::ENTRY_FREE);
  assign ent_link = !rd_data[fba_pkg::ENTRY_W-1] && (rd_data < fba_pkg::TBL_LIM);
  assign cur_blk  = fba_pkg::BLOCK_W'(cur_r);

  fba_ram #(
    .WIDTH (fba_pkg::ENTRY_W),
    .DEPTH (fba_pkg::TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    rd_addr   = cur_r;
    wr_en     = 1'b0;
    wr_addr   = cur_r;
    wr_data   = fba_pkg::ENTRY_END;
    set_vld   = 1'b0;
    clr_vld   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt   = fba_pkg::BLOCK_NONE;
          err_nxt   = 1'b0;
          steps_nxt = '0;
          state_nxt = ST_FIN;
          unique case (in_mode)
            fba_pkg::MODE_ALLOC: begin
              rd_addr   = '0;
              cur_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            fba_pkg::MODE_FREE: begin
              wr_addr = blk_idx;
              clr_vld = blk_ok;
            end
            fba_pkg::MODE_LAST: begin
              if (blk_ok) begin
                rd_addr   = blk_idx;
                cur_nxt   = blk_idx;
                state_nxt = ST_WALK;
              end
            end
            fba_pkg::MODE_LINK: begin
              wr_en   = blk_ok && nxt_ok;
              set_vld = blk_ok && nxt_ok;
              wr_addr = blk_idx;
              wr_data = fba_pkg::entry_t'(in_next_block);
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_addr = cur_r + 1'b1;
        cur_nxt = cur_r + 1'b1;
        priority if (ent_free) begin
          wr_en     = 1'b1;
          set_vld   = 1'b1;
          wr_data   = fba_pkg::ENTRY_END;
          res_nxt   = cur_blk;
          state_nxt = ST_FIN;
        end else if (cur_r == fba_pkg::IDX_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_WALK: begin
        rd_addr   = rd_data[fba_pkg::IDX_W-1:0];
        cur_nxt   = rd_data[fba_pkg::IDX_W-1:0];
        steps_nxt = steps_r + 1'b1;
        priority if (!vld_q_r) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (rd_data == fba_pkg::ENTRY_END) begin
          res_nxt   = cur_blk;
          state_nxt = ST_FIN;
        end else if (!ent_link || steps_r == fba_pkg::IDX_LAST) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (set_vld) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (clr_vld) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (state_r == ST_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    err_r   <= err_nxt;
    vld_q_r <= valid_r[rd_addr];
    if (state_r == ST_FIN && slot_free) begin
      out_res_r <= res_r;
      out_err_r <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_res_r;
  assign out_chain_error  = out_err_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted word did not start work");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && slot_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished word not moved to output");

  a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_res_r == fba_pkg::BLOCK_NONE)
    else $error("chain error with a block result");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && state_nxt == ST_SCAN |=> cur_r == $past(cur_r) + 1'b1)
    else $error("scan skipped an entry");

endmodule
